[design/hce_pkg.sv]
// Package for the histogram cardinality estimator.
// Holds shared codes and the sequencer state type; no dependencies.
package hce_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] KIND_EQ = 3'd0;
  localparam logic [2:0] KIND_LT = 3'd1;
  localparam logic [2:0] KIND_LE = 3'd2;
  localparam logic [2:0] KIND_GT = 3'd3;
  localparam logic [2:0] KIND_GE = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_TOT    = 7'b0000010,
    S_SRCH   = 7'b0000100,
    S_WAIT   = 7'b0001000,
    S_FETCH  = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

endpackage

[design/hce_ram.sv]
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module hce_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[design/hce_div.sv]
// Serial restoring fixed-point divider: floor(num*2^FracBits/den), saturating.
// Uses no package items.
module hce_div #(
  parameter int FreqWidth = 48,
  parameter int FracBits  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [FreqWidth-1:0] num_i,
  input  logic [FreqWidth-1:0] den_i,
  output logic                 done_o,
  output logic [FreqWidth-1:0] quot_o
);

  localparam int Steps = FreqWidth + FracBits;
  localparam int CntW  = $clog2(Steps + 1);

  logic [FreqWidth-1:0] num_q, num_d, den_q, den_d, q_q, q_d;
  logic [FreqWidth:0]   rem_q, rem_d, shifted;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 run_q, run_d, sat_q, sat_d, done_q, done_d;

  // One quotient bit per cycle.
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    q_d    = q_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    sat_d  = sat_q;
    done_d = 1'b0;
    shifted = {rem_q[FreqWidth-1:0], num_q[FreqWidth-1]};
    if (start_i) begin
      num_d = num_i;
      den_d = den_i;
      q_d   = '0;
      rem_d = '0;
      sat_d = 1'b0;
      cnt_d = CntW'(Steps);
      run_d = 1'b1;
    end else if (run_q) begin
      if (cnt_q > CntW'(FracBits)) begin
        num_d = {num_q[FreqWidth-2:0], 1'b0};
      end else begin
        shifted = {rem_q[FreqWidth-1:0], 1'b0};
      end
      if (q_q[FreqWidth-1]) begin
        sat_d = 1'b1;
      end
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        q_d   = {q_q[FreqWidth-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        q_d   = {q_q[FreqWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    q_q   <= q_d;
    rem_q <= rem_d;
    sat_q <= sat_d;
  end

  assign done_o = done_q;
  assign quot_o = sat_q ? '1 : q_q;

endmodule

[design/histogram_cardinality_estimator_top.sv]
// Top level of the histogram cardinality estimator.
// Uses hce_pkg, hce_ram and hce_div.
//
// Channel   Direction  Handshake             Payload
// cmd       in         start_i & !busy_o     operation_i .. query_kind_i
// result    out        done_o (one cycle)    status_o, card_estimate_o, distinct_estimate_o
// config    in         APB psel/penable      bucket_count at address 0
//
// A load goes straight to the done state and strobes its result in the cycle after that.
// A query passes the totals read (S_TOT), S_WAIT and S_SRCH per search step (9 steps at
// 256 buckets), the bucket fetch (S_FETCH) and the result state (S_DONE), plus the divider
// (S_DIV) on an equality query whose key lies inside a bucket's range, not on its bound.
// Reset clears the control state and bucket_count; the tables hold no reset.
// The result strobe lasts one cycle; the receiver cannot stall it.
module histogram_cardinality_estimator_top #(
  parameter int MAX_BUCKETS = 256,
  parameter int FREQ_WIDTH  = 48,
  parameter int FRAC_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  operation_i,
  input  logic [7:0]            bucket_index_i,
  input  logic signed [63:0]    bound_key_i,
  input  logic [FREQ_WIDTH-1:0] equal_freq_i,
  input  logic [FREQ_WIDTH-1:0] range_freq_i,
  input  logic [FREQ_WIDTH-1:0] cumulative_freq_i,
  input  logic [FREQ_WIDTH-1:0] range_distinct_i,
  input  logic [FREQ_WIDTH-1:0] cumulative_distinct_i,
  input  logic signed [63:0]    query_key_i,
  input  logic [2:0]            query_kind_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [FREQ_WIDTH-1:0] card_estimate_o,
  output logic [FREQ_WIDTH-1:0] distinct_estimate_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int AW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CW   = $clog2(MAX_BUCKETS + 1);
  localparam int FW   = FREQ_WIDTH;
  localparam int BW   = 5 * FW;
  localparam logic [FW-1:0] FxOne = FW'(1) << FRAC_BITS;
  localparam logic [0:0] REG_BUCKET_COUNT_A = hce_pkg::REG_BUCKET_COUNT;

  // Configuration register.
  logic [8:0] bucket_count_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= '0;
    end else if (psel && penable && pwrite && paddr[1:1] == REG_BUCKET_COUNT_A) begin
      bucket_count_q <= pwdata[8:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr[1:1] == REG_BUCKET_COUNT_A) ? {23'd0, bucket_count_q} : '0;

  logic [CW-1:0] n_act;
  assign n_act = ({23'd0, bucket_count_q} > 32'(MAX_BUCKETS)) ? CW'(MAX_BUCKETS)
               : CW'(bucket_count_q);

  // Memories.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [63:0]   bound_rd;
  logic [BW-1:0] bkt_rd;
  logic [BW-1:0] bkt_wd;

  hce_ram #(.Width(64), .Depth(MAX_BUCKETS)) u_bound (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i(bound_key_i ^ {1'b1, 63'd0}), .rdata_o(bound_rd));

  hce_ram #(.Width(BW), .Depth(MAX_BUCKETS)) u_bucket (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i(bkt_wd), .rdata_o(bkt_rd));

  assign bkt_wd = {cumulative_distinct_i, range_distinct_i, cumulative_freq_i,
                   range_freq_i, equal_freq_i};

  logic [FW-1:0] b_eq, b_rng, b_cum, b_ndv, b_cndv;
  assign {b_cndv, b_ndv, b_cum, b_rng, b_eq} = bkt_rd;

  // Load checks.
  logic slot_bad, bkt_bad;
  assign slot_bad = {24'd0, bucket_index_i} >= 32'(MAX_BUCKETS);
  assign bkt_bad = (range_distinct_i > range_freq_i)
                || ({1'b0, cumulative_freq_i} < {1'b0, equal_freq_i} + {1'b0, range_freq_i})
                || ({1'b0, cumulative_distinct_i} < {1'b0, range_distinct_i} + {1'b0, FxOne});

  // Sequencer.
  hce_pkg::state_e st_q, st_d;
  logic [CW-1:0]  idx_q, idx_d, len_q, len_d, half_q, half_d;
  logic [63:0]    key_q, key_d;
  logic [2:0]     kind_q, kind_d;
  logic [FW-1:0]  tc_q, tc_d, td_q, td_d, card_q, card_d, dist_q, dist_d;
  logic [1:0]     stat_q, stat_d;
  logic           done_q, done_d, tot_wait_q, tot_wait_d;
  logic           div_start, div_done;
  logic [FW-1:0]  div_q;

  hce_div #(.FreqWidth(FW), .FracBits(FRAC_BITS)) u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(b_rng),
    .den_i(b_ndv), .done_o(div_done), .quot_o(div_q));

  function automatic logic [FW-1:0] ssub(logic [FW-1:0] a, logic [FW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  logic [2:0]    bk;
  logic          endp;
  logic [FW-1:0] bc, bd;

  always_comb begin
    // Base estimate of a less-type or equal predicate from the fetched bucket.
    bk = (kind_q == hce_pkg::KIND_GT) ? hce_pkg::KIND_LE
       : (kind_q == hce_pkg::KIND_GE) ? hce_pkg::KIND_LT : kind_q;
    endp = (bound_rd == key_q);
    if (bk == hce_pkg::KIND_LT) begin
      bc = ssub(b_cum, b_eq);
      bd = ssub(b_cndv, FxOne);
      if (!endp) begin
        bc = ssub(bc, b_rng >> 1);
        bd = ssub(bd, b_ndv >> 1);
      end
    end else begin
      bc = b_cum;
      bd = b_cndv;
      if (!endp) begin
        bc = ssub(ssub(bc, b_eq), b_rng >> 1);
        bd = ssub(ssub(bd, FxOne), b_ndv >> 1);
      end
    end
  end

  always_comb begin
    st_d = st_q; idx_d = idx_q; len_d = len_q; half_d = half_q;
    key_d = key_q; kind_d = kind_q; tc_d = tc_q; td_d = td_q;
    card_d = card_q; dist_d = dist_q; stat_d = stat_q;
    done_d = 1'b0; tot_wait_d = 1'b0; div_start = 1'b0;
    ram_we = 1'b0;
    ram_addr = idx_q[AW-1:0] + half_q[AW-1:0];
    case (st_q)
      hce_pkg::S_IDLE: begin
        ram_addr = AW'(bucket_index_i);
        if (start_i) begin
          card_d = '0; dist_d = '0; stat_d = hce_pkg::ST_OK;
          key_d = query_key_i ^ {1'b1, 63'd0};
          kind_d = query_kind_i;
          if (operation_i == hce_pkg::OP_LOAD) begin
            if (slot_bad) stat_d = hce_pkg::ST_RANGE;
            else if (bkt_bad) stat_d = hce_pkg::ST_INVALID;
            else ram_we = 1'b1;
            st_d = hce_pkg::S_DONE;
          end else if (query_kind_i > hce_pkg::KIND_GE) begin
            st_d = hce_pkg::S_DONE;
          end else begin
            // Read the last active bucket for the totals.
            ram_addr = AW'(n_act - 1'b1);
            tot_wait_d = 1'b1;
            st_d = hce_pkg::S_TOT;
          end
        end
      end
      hce_pkg::S_TOT: begin
        if (n_act == '0) begin
          tc_d = '0; td_d = '0;
        end else begin
          tc_d = b_cum; td_d = b_cndv;
        end
        idx_d = '0; len_d = n_act; half_d = n_act >> 1;
        ram_addr = AW'(n_act >> 1);
        st_d = (n_act == '0) ? hce_pkg::S_FETCH : hce_pkg::S_WAIT;
      end
      hce_pkg::S_WAIT: begin
        // Bound read issued last cycle lands now.
        st_d = hce_pkg::S_SRCH;
      end
      hce_pkg::S_SRCH: begin
        if (bound_rd < key_q) begin
          idx_d = idx_q + half_q + 1'b1;
          len_d = len_q - half_q - 1'b1;
        end else begin
          len_d = half_q;
        end
        half_d = len_d >> 1;
        ram_addr = idx_d[AW-1:0] + half_d[AW-1:0];
        if (len_d == '0) begin
          ram_addr = idx_d[AW-1:0];
          st_d = hce_pkg::S_FETCH;
          tot_wait_d = 1'b1;
        end else begin
          st_d = hce_pkg::S_WAIT;
        end
      end
      hce_pkg::S_FETCH: begin
        ram_addr = idx_q[AW-1:0];
        if (!tot_wait_q && n_act != '0) begin
          // Read at idx is still in flight; wait for it.
          tot_wait_d = 1'b1;
        end else if (idx_q >= n_act) begin
          if (kind_q == hce_pkg::KIND_EQ) begin
            card_d = '0; dist_d = '0;
          end else if (kind_q == hce_pkg::KIND_LT || kind_q == hce_pkg::KIND_LE) begin
            card_d = tc_q; dist_d = td_q;
          end else begin
            card_d = '0; dist_d = '0;
          end
          st_d = hce_pkg::S_DONE;
        end else if (kind_q == hce_pkg::KIND_EQ) begin
          dist_d = FxOne;
          if (endp) begin
            card_d = b_eq; st_d = hce_pkg::S_DONE;
          end else if (b_ndv == '0) begin
            card_d = '0; st_d = hce_pkg::S_DONE;
          end else begin
            div_start = 1'b1; st_d = hce_pkg::S_DIV;
          end
        end else if (kind_q == hce_pkg::KIND_LT || kind_q == hce_pkg::KIND_LE) begin
          card_d = bc; dist_d = bd; st_d = hce_pkg::S_DONE;
        end else begin
          card_d = ssub(tc_q, bc); dist_d = ssub(td_q, bd); st_d = hce_pkg::S_DONE;
        end
      end
      hce_pkg::S_DIV: begin
        ram_addr = idx_q[AW-1:0];
        if (div_done) begin
          card_d = div_q; st_d = hce_pkg::S_DONE;
        end
      end
      hce_pkg::S_DONE: begin
        done_d = 1'b1;
        st_d = hce_pkg::S_IDLE;
      end
      default: st_d = hce_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= hce_pkg::S_IDLE;
      done_q <= 1'b0;
      tot_wait_q <= 1'b0;
    end else begin
      st_q <= st_d;
      done_q <= done_d;
      tot_wait_q <= tot_wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; len_q <= len_d; half_q <= half_d;
    key_q <= key_d; kind_q <= kind_d; tc_q <= tc_d; td_q <= td_d;
    card_q <= card_d; dist_q <= dist_d; stat_q <= stat_d;
  end

  assign busy_o = (st_q != hce_pkg::S_IDLE);
  assign done_o = done_q;
  assign status_o = stat_q;
  assign card_estimate_o = card_q;
  assign distinct_estimate_o = dist_q;

endmodule

[test/histogram_cardinality_estimator_top_tb.sv]
// Testbench for the histogram cardinality estimator top level.
// Depends on hce_pkg and histogram_cardinality_estimator_top; self-checking with a scoreboard.
// Loads bucket tables, sweeps bucket_count over the APB port and checks every query estimate.
module histogram_cardinality_estimator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NSLOT   = 256;
  localparam logic [47:0] FMASK   = {48{1'b1}};
  localparam logic [47:0] FONE    = 48'h1_0000;
  localparam int          STALL_LIMIT = 4000;

  typedef struct {
    logic               op;
    logic [7:0]         slot;
    logic signed [63:0] bkey;
    logic [47:0]        eq, rng, cum, ndv, cndv;
    logic signed [63:0] qkey;
    logic [2:0]         kind;
  } item_t;

  typedef struct {
    logic [1:0]  status;
    logic [47:0] card;
    logic [47:0] dcount;
  } estimate_t;

  // Scoreboard: a private copy of the bucket table and the queue of pending estimates.
  class hist_scoreboard;
    logic signed [63:0] bound[NSLOT];
    logic [47:0]        b_eq[NSLOT], b_rng[NSLOT], b_cum[NSLOT], b_ndv[NSLOT], b_cndv[NSLOT];
    logic [8:0]         count;
    estimate_t          pending_q[$];
    int                 errors, seen, loads_ok, loads_bad, queries;

    function new();
      count = 0;
      errors = 0;
      seen = 0;
      loads_ok = 0;
      loads_bad = 0;
      queries = 0;
      foreach (bound[i]) bound[i] = 0;
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction

    function void set_count(logic [8:0] value);
      count = value;
    endfunction

    function int active();
      return (count > NSLOT) ? NSLOT : int'(count);
    endfunction

    function logic [47:0] sub0(logic [47:0] a, logic [47:0] b);
      return (a > b) ? a - b : 48'd0;
    endfunction

    function void mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
      errors++;
      if (errors <= 10)
        $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, act_v);
    endfunction

    function void table_totals(output logic [47:0] c, output logic [47:0] d);
      int n;
      n = active();
      c = (n == 0) ? 48'd0 : b_cum[n-1];
      d = (n == 0) ? 48'd0 : b_cndv[n-1];
    endfunction

    // Equal, less or less-equal estimate; the first bound not below the key picks the bucket.
    function void lower_estimate(logic signed [63:0] key, logic [2:0] kind,
                                 output logic [47:0] c, output logic [47:0] d);
      int           n, idx, len, half;
      bit           hit;
      logic [111:0] quot;
      n = active();
      idx = 0;
      len = n;
      while (len > 0) begin
        half = len >> 1;
        if (bound[idx+half] < key) begin
          idx += half + 1;
          len -= half + 1;
        end else begin
          len = half;
        end
      end
      if (idx >= n) begin
        if (kind == hce_pkg::KIND_EQ) begin
          c = 0;
          d = 0;
        end else begin
          table_totals(c, d);
        end
        return;
      end
      hit = (bound[idx] == key);
      if (kind == hce_pkg::KIND_EQ) begin
        if (hit) begin
          c = b_eq[idx];
        end else if (b_ndv[idx] == 0) begin
          c = 0;
        end else begin
          quot = {b_rng[idx], 16'd0} / {64'd0, b_ndv[idx]};
          c = (quot > {64'd0, FMASK}) ? FMASK : quot[47:0];
        end
        d = FONE;
      end else if (kind == hce_pkg::KIND_LT) begin
        c = sub0(b_cum[idx], b_eq[idx]);
        d = sub0(b_cndv[idx], FONE);
        if (!hit) begin
          c = sub0(c, b_rng[idx] >> 1);
          d = sub0(d, b_ndv[idx] >> 1);
        end
      end else begin
        c = b_cum[idx];
        d = b_cndv[idx];
        if (!hit) begin
          c = sub0(sub0(c, b_eq[idx]), b_rng[idx] >> 1);
          d = sub0(sub0(d, FONE), b_ndv[idx] >> 1);
        end
      end
    endfunction

    function estimate_t predict(item_t it);
      estimate_t   r;
      logic [47:0] tc, td, c, d;
      r.status = hce_pkg::ST_OK;
      r.card = 0;
      r.dcount = 0;
      if (it.op == hce_pkg::OP_LOAD) begin
        // An 8-bit slot always lies inside the 256-entry table, so no range error here.
        if (it.ndv > it.rng || {1'b0, it.cum} < {1'b0, it.eq} + it.rng ||
            {1'b0, it.cndv} < {1'b0, it.ndv} + FONE) begin
          r.status = hce_pkg::ST_INVALID;
          loads_bad++;
        end else begin
          bound[it.slot] = it.bkey;
          b_eq[it.slot] = it.eq;
          b_rng[it.slot] = it.rng;
          b_cum[it.slot] = it.cum;
          b_ndv[it.slot] = it.ndv;
          b_cndv[it.slot] = it.cndv;
          loads_ok++;
        end
      end else begin
        queries++;
        if (it.kind <= hce_pkg::KIND_LE) begin
          lower_estimate(it.qkey, it.kind, r.card, r.dcount);
        end else if (it.kind <= hce_pkg::KIND_GE) begin
          table_totals(tc, td);
          lower_estimate(it.qkey, (it.kind == hce_pkg::KIND_GT) ? hce_pkg::KIND_LE
                                                                : hce_pkg::KIND_LT, c, d);
          r.card = sub0(tc, c);
          r.dcount = sub0(td, d);
        end
      end
      return r;
    endfunction

    function void note_item(item_t it);
      pending_q.push_back(predict(it));
    endfunction

    function void check_result(estimate_t got);
      estimate_t e;
      seen++;
      if (pending_q.size() == 0) begin
        mismatch("result with no item waiting", 0, {got.status, got.card});
        return;
      end
      e = pending_q.pop_front();
      if (got.status !== e.status) mismatch("status", e.status, got.status);
      if (got.card !== e.card) mismatch("card_estimate", e.card, got.card);
      if (got.dcount !== e.dcount) mismatch("distinct_estimate", e.dcount, got.dcount);
    endfunction
  endclass

  logic               clk_i, rst_ni, start_i, busy_o;
  logic               operation_i;
  logic [7:0]         bucket_index_i;
  logic signed [63:0] bound_key_i, query_key_i;
  logic [47:0]        equal_freq_i, range_freq_i, cumulative_freq_i;
  logic [47:0]        range_distinct_i, cumulative_distinct_i;
  logic [2:0]         query_kind_i;
  logic               done_o;
  logic [1:0]         status_o;
  logic [47:0]        card_estimate_o, distinct_estimate_o;
  logic               psel, penable, pwrite, pready;
  logic [1:0]         paddr;
  logic [31:0]        pwdata, prdata;

  hist_scoreboard sb;
  int  sent;
  int  stall_cycles;
  bit  steady;
  int  counts_used[$];

  histogram_cardinality_estimator_top dut (.*);

  // Clock.
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Result monitor; the strobe lasts one cycle and is sampled at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result('{status: status_o, card: card_estimate_o,
                        dcount: distinct_estimate_o});
  end

  // Watchdog on cycles in which neither an item nor a result moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("histogram_cardinality_estimator_top_tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [47:0] rnd48();
    logic [63:0] full;
    full = {$urandom, $urandom};
    return full[47:0] >> $urandom_range(0, 47);
  endfunction

  function automatic logic signed [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // A bucket that passes every load check, with a spread of distinct counts.
  function automatic item_t good_bucket(logic [7:0] slot, logic signed [63:0] key);
    item_t it;
    it = '{default: '0};
    it.op = hce_pkg::OP_LOAD;
    it.slot = slot;
    it.bkey = key;
    it.rng = rnd48() >> 2;
    case ($urandom_range(0, 3))
      0: it.ndv = 0;
      1: it.ndv = (it.rng != 0) ? 48'd1 : 48'd0;
      2: it.ndv = it.rng >> $urandom_range(1, 40);
      default: it.ndv = it.rng;
    endcase
    it.eq = rnd48() >> 2;
    it.cum = it.eq + it.rng + (($urandom_range(0, 3) == 0) ? 48'd0 : rnd48() >> 2);
    it.cndv = it.ndv + FONE + (($urandom_range(0, 3) == 0) ? 48'd0 : rnd48() >> 2);
    it.qkey = rnd64();
    it.kind = 3'($urandom);
    return it;
  endfunction

  function automatic item_t query_item(logic signed [63:0] key, logic [2:0] kind);
    item_t it;
    it = '{default: '0};
    it.op = hce_pkg::OP_QUERY;
    it.qkey = key;
    it.kind = kind;
    it.slot = 8'($urandom);
    it.bkey = rnd64();
    return it;
  endfunction

  // Keys land on stored bounds, next to them, on the extremes or anywhere.
  function automatic logic signed [63:0] pick_key();
    int n, r;
    logic signed [63:0] k;
    n = sb.active();
    r = $urandom_range(0, 99);
    k = sb.bound[$urandom_range(0, (n > 0) ? n - 1 : 0)];
    if (r < 40) return k;
    if (r < 50) return k + 1;
    if (r < 60) return k - 1;
    if (r < 65) return 64'sh8000_0000_0000_0000;
    if (r < 70) return 64'sh7fff_ffff_ffff_ffff;
    return rnd64();
  endfunction

  // Present one item at a falling edge and hold it until the block takes it.
  task automatic send_item(item_t it);
    if (!steady && $urandom_range(0, 99) < 36) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    operation_i <= it.op;
    bucket_index_i <= it.slot;
    bound_key_i <= it.bkey;
    equal_freq_i <= it.eq;
    range_freq_i <= it.rng;
    cumulative_freq_i <= it.cum;
    range_distinct_i <= it.ndv;
    cumulative_distinct_i <= it.cndv;
    query_key_i <= it.qkey;
    query_kind_i <= it.kind;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(it);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (90) @(negedge clk_i);
  endtask

  // Change bucket_count only while idle, then read it back.
  task automatic write_count(logic [31:0] value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'(4 * hce_pkg::REG_BUCKET_COUNT);
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_count(value[8:0]);
    counts_used.push_back(int'(value[8:0]));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[8:0] !== value[8:0]) sb.mismatch("bucket_count readback", value[8:0], prdata);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    item_t              it;
    logic signed [63:0] key;
    int                 r, n;
    int                 phase_counts[13];

    phase_counts = '{1, 2, 5, 16, 256, 511, 0, 3, 100, 255, 9, 300, 0};
    sb = new();
    sent = 0;
    steady = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    operation_i = hce_pkg::OP_LOAD;
    bucket_index_i = '0;
    bound_key_i = '0;
    equal_freq_i = '0;
    range_freq_i = '0;
    cumulative_freq_i = '0;
    range_distinct_i = '0;
    cumulative_distinct_i = '0;
    query_key_i = '0;
    query_kind_i = hce_pkg::KIND_EQ;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty table: every kind, the unknown ones too, gives totals of zero.
    for (int k = 0; k < 8; k++) send_item(query_item(64'sd0, 3'(k)));

    // Each load check gets an item built to break it.
    it = good_bucket(8'd3, 64'sd0);
    it.rng = FONE;
    it.ndv = FONE + 1;
    it.cum = FMASK;
    it.cndv = FMASK;
    send_item(it);
    it = good_bucket(8'd4, 64'sd0);
    it.eq = FONE;
    it.rng = FONE;
    it.cum = 2 * FONE - 1;
    send_item(it);
    it = good_bucket(8'd5, 64'sd0);
    it.ndv = FONE;
    it.rng = FONE;
    it.cum = FMASK;
    it.cndv = 2 * FONE - 1;
    send_item(it);

    // Two buckets: a plain one and one at the top of every range, whose divide saturates.
    it = good_bucket(8'd0, -64'sd100);
    it.eq = 3 * FONE;
    it.rng = 1000 * FONE;
    it.ndv = FONE;
    it.cum = 1003 * FONE;
    it.cndv = 2 * FONE;
    send_item(it);
    it = good_bucket(8'd1, 64'sh7fff_ffff_ffff_ffff);
    it.rng = 48'h8000_0000_0000;
    it.ndv = 48'd1;
    it.eq = FMASK - 48'h8000_0000_0000;
    it.cum = FMASK;
    it.cndv = FMASK;
    send_item(it);
    write_count(32'd2);
    send_item(query_item(64'sh8000_0000_0000_0000, hce_pkg::KIND_EQ));
    send_item(query_item(64'sh8000_0000_0000_0000, hce_pkg::KIND_LT));
    send_item(query_item(64'sh8000_0000_0000_0000, hce_pkg::KIND_GE));
    send_item(query_item(-64'sd100, hce_pkg::KIND_LE));
    send_item(query_item(-64'sd100, hce_pkg::KIND_GT));
    send_item(query_item(64'sd5, hce_pkg::KIND_EQ));
    send_item(query_item(64'sd5, hce_pkg::KIND_LT));
    send_item(query_item(64'sh7fff_ffff_ffff_ffff, hce_pkg::KIND_EQ));
    write_count(32'd1);
    send_item(query_item(64'sd5, hce_pkg::KIND_EQ));
    send_item(query_item(64'sd5, hce_pkg::KIND_LE));

    // Fill the whole table with ascending bounds, some repeated, so every count is safe.
    key = 64'sh8000_0000_0000_0000;
    for (int s = 0; s < NSLOT; s++) begin
      send_item(good_bucket(8'(s), key));
      if ($urandom_range(0, 9) != 0) key = key + ({$urandom, $urandom} >> 10);
    end

    // Random phases over a range of table sizes, the extremes among them.
    foreach (phase_counts[p]) begin
      write_count((p == 12) ? $urandom_range(0, 511) : phase_counts[p]);
      n = sb.active();
      for (int i = 0; i < 120; i++) begin
        steady = (sent >= 700 && sent < 950);
        r = $urandom_range(0, 99);
        if (r < 55) begin
          send_item(query_item(pick_key(), ($urandom_range(0, 19) == 0)
                                           ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4))));
        end else if (r < 85) begin
          it.slot = (n > 0 && $urandom_range(0, 9) < 6) ? 8'($urandom_range(0, n - 1))
                                                        : 8'($urandom);
          send_item(good_bucket(it.slot, ($urandom_range(0, 9) < 7) ? sb.bound[it.slot]
                                                                    : rnd64()));
        end else begin
          // Noise: raw fields, mostly rejected.
          it = '{op: hce_pkg::OP_LOAD, slot: 8'($urandom), bkey: rnd64(),
                 eq: 48'({$urandom, $urandom}), rng: 48'({$urandom, $urandom}),
                 cum: 48'({$urandom, $urandom}), ndv: 48'({$urandom, $urandom}),
                 cndv: 48'({$urandom, $urandom}), qkey: rnd64(), kind: 3'($urandom)};
          send_item(it);
        end
        // Now and then hold off until every estimate is back.
        if (i == 60 && p % 4 == 1) begin
          start_i <= 1'b0;
          while (sb.outstanding() != 0) @(posedge clk_i);
          @(negedge clk_i);
        end
      end
    end

    drain();
    $display("Sent %0d items: %0d queries, %0d loads taken, %0d loads rejected.",
             sent, sb.queries, sb.loads_ok, sb.loads_bad);
    $display("Checked %0d results over %0d bucket_count settings; %0d mismatches.",
             sb.seen, counts_used.size(), sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("histogram_cardinality_estimator_top_tb: clean");
    end else begin
      $display("histogram_cardinality_estimator_top_tb: errors");
    end
    $finish;
  end

endmodule
